/* rtl/lfpd_pkg.sv */
package lfpd_pkg;

    localparam int NUM_LANES    = 8;
    localparam int SENSOR_COUNT = 8;
    localparam int MAX_DRIVE    = 150;

    localparam int WEIGHT_W = 8;
    localparam int SUM_W    = 11;
    localparam int CNT_W    = 4;
    localparam int POS_W    = 9;
    localparam int WORD_W   = 16;
    localparam int CFG_W    = 64;
    localparam int CFG_IDX_W = 4;

    localparam int DIV_BITS      = 12;
    localparam int DIV_STEP_BITS = 3;
    localparam int DIV_PASSES    = DIV_BITS / DIV_STEP_BITS;
    localparam int DIV_PASS_W    = $clog2(DIV_PASSES);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_P      = 4'd0,
        CFG_GAIN_D      = 4'd1,
        CFG_TARGET      = 4'd2,
        CFG_BASE_SPEED  = 4'd3,
        CFG_TURN_SPEED  = 4'd4,
        CFG_TURN_THRESH = 4'd5,
        CFG_LOST_ERROR  = 4'd6,
        CFG_WEIGHTS     = 4'd7
    } t_cfg_reg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SUM,
        S_CHK,
        S_DIV,
        S_PD,
        S_OUT
    } t_state;

    typedef struct packed {
        logic                       active;
        logic signed [WEIGHT_W-1:0] contrib;
    } t_lane;

    typedef struct packed {
        logic             neg;
        logic [SUM_W-1:0] mag;
        logic [CNT_W-1:0] cnt;
    } t_merge;

    typedef struct packed {
        logic [7:0] mag;
        logic       rev;
    } t_drive;

    function automatic t_drive clamp_drive(input logic signed [WORD_W-1:0] v);
        t_drive d;
        logic signed [WORD_W-1:0] lim;
        lim = WORD_W'(MAX_DRIVE);
        if (!v[WORD_W-1]) begin
            d.rev = 1'b0;
            d.mag = (v > lim) ? 8'(MAX_DRIVE) : v[7:0];
        end else begin
            d.rev = 1'b1;
            d.mag = (v < -lim) ? 8'(MAX_DRIVE) : 8'(-v);
        end
        return d;
    endfunction

endpackage

/* rtl/lfpd_lane.sv */
module lfpd_lane (
    input  logic                                i_enable,
    input  logic                                i_sensor,
    input  logic [lfpd_pkg::WEIGHT_W-1:0]       i_weight,
    output lfpd_pkg::t_lane                     o_lane
);

    always_comb begin
        o_lane.active  = i_enable & i_sensor;
        o_lane.contrib = o_lane.active ? $signed(i_weight) : '0;
    end

endmodule

/* rtl/lfpd_merge.sv */
module lfpd_merge (
    input  logic                                   i_clk,
    input  logic                                   i_load,
    input  lfpd_pkg::t_lane [lfpd_pkg::NUM_LANES-1:0] i_lanes,
    output lfpd_pkg::t_merge                       o_merge
);

    logic signed [lfpd_pkg::SUM_W-1:0] n_sum;
    logic [lfpd_pkg::CNT_W-1:0]        n_cnt;
    lfpd_pkg::t_merge                  r_merge;

    always_comb begin
        n_sum = '0;
        n_cnt = '0;
        for (int i = 0; i < lfpd_pkg::NUM_LANES; i++) begin
            n_sum = n_sum + lfpd_pkg::SUM_W'(i_lanes[i].contrib);
            n_cnt = n_cnt + lfpd_pkg::CNT_W'(i_lanes[i].active);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_merge.neg <= n_sum[lfpd_pkg::SUM_W-1];
            r_merge.mag <= n_sum[lfpd_pkg::SUM_W-1] ? lfpd_pkg::SUM_W'(-n_sum)
                                                    : lfpd_pkg::SUM_W'(n_sum);
            r_merge.cnt <= n_cnt;
        end
    end

    assign o_merge = r_merge;

endmodule

/* rtl/lfpd_div.sv */
module lfpd_div (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic [lfpd_pkg::SUM_W-1:0]         i_dividend,
    input  logic [lfpd_pkg::CNT_W-1:0]         i_divisor,
    input  logic                               i_neg,
    output logic                               o_done,
    output logic signed [lfpd_pkg::POS_W-1:0]  o_quot
);

    logic                            r_busy;
    logic                            r_done;
    logic [lfpd_pkg::DIV_PASS_W-1:0] r_pass;
    logic [lfpd_pkg::DIV_BITS-1:0]   r_num;
    logic [lfpd_pkg::DIV_BITS-1:0]   r_quot;
    logic [lfpd_pkg::CNT_W-1:0]      r_rem;
    logic [lfpd_pkg::CNT_W-1:0]      r_div;
    logic                            r_neg;

    logic [lfpd_pkg::DIV_BITS-1:0]   n_num;
    logic [lfpd_pkg::DIV_BITS-1:0]   n_quot;
    logic [lfpd_pkg::CNT_W-1:0]      n_rem;
    logic [lfpd_pkg::CNT_W:0]        w_trial;
    logic [lfpd_pkg::DIV_BITS-1:0]   w_qneg;

    // restoring division, DIV_STEP_BITS quotient bits per cycle
    always_comb begin
        n_num  = r_num;
        n_quot = r_quot;
        n_rem  = r_rem;
        w_trial = '0;
        for (int k = 0; k < lfpd_pkg::DIV_STEP_BITS; k++) begin
            w_trial = {n_rem, n_num[lfpd_pkg::DIV_BITS-1]};
            n_num   = {n_num[lfpd_pkg::DIV_BITS-2:0], 1'b0};
            if (w_trial >= {1'b0, r_div}) begin
                n_rem  = lfpd_pkg::CNT_W'(w_trial - {1'b0, r_div});
                n_quot = {n_quot[lfpd_pkg::DIV_BITS-2:0], 1'b1};
            end else begin
                n_rem  = w_trial[lfpd_pkg::CNT_W-1:0];
                n_quot = {n_quot[lfpd_pkg::DIV_BITS-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_pass <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_pass <= '0;
            end else if (r_busy) begin
                r_pass <= r_pass + 1'b1;
                if (r_pass == lfpd_pkg::DIV_PASS_W'(lfpd_pkg::DIV_PASSES - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num  <= lfpd_pkg::DIV_BITS'(i_dividend);
            r_quot <= '0;
            r_rem  <= '0;
            r_div  <= i_divisor;
            r_neg  <= i_neg;
        end else if (r_busy) begin
            r_num  <= n_num;
            r_quot <= n_quot;
            r_rem  <= n_rem;
        end
    end

    assign w_qneg = r_neg ? -r_quot : r_quot;
    assign o_quot = $signed(w_qneg[lfpd_pkg::POS_W-1:0]);
    assign o_done = r_done;

endmodule

/* rtl/line_follow_pd_drive_top.sv */
// Line follower PD drive controller.
// Input channel (i_valid/o_ready): one beat is one scan of eight line sensors.
// Output channel (o_valid/i_ready): one beat per scan with both motor drives
// (magnitude plus reverse flag), the computed line position and a lost flag.
// Configuration: i_cfg_wr_en writes i_cfg_data into register i_cfg_index at
// the clock edge; indexes above 7 are ignored. Write only while idle.
// Steps on a line scan: lane sum, a check that also starts the divider, the
// divider (4 passes of 3 quotient bits, then the done flag), the PD multiply
// and the output register; when the line is lost the check bypasses the
// divider. One scan is in flight at a time: a new scan is accepted only
// after the previous result is loaded, and the input is ready again in the
// cycle after that load. A finished result waits in the output register;
// the next scan is accepted meanwhile and stalls in its final step only if
// the previous result has still not been taken. Reset (synchronous, active
// low) clears the FSM, configuration, divider control, output valid flag,
// position history and last error; datapath registers are not reset.
module line_follow_pd_drive_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_wr_en,
    input  logic [lfpd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [lfpd_pkg::CFG_W-1:0]         i_cfg_data,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic                               i_sensor_0,
    input  logic                               i_sensor_1,
    input  logic                               i_sensor_2,
    input  logic                               i_sensor_3,
    input  logic                               i_sensor_4,
    input  logic                               i_sensor_5,
    input  logic                               i_sensor_6,
    input  logic                               i_sensor_7,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [7:0]                         o_left_drive,
    output logic                               o_left_reverse,
    output logic [7:0]                         o_right_drive,
    output logic                               o_right_reverse,
    output logic signed [lfpd_pkg::POS_W-1:0]  o_line_position,
    output logic                               o_line_lost
);

    localparam int W = lfpd_pkg::WORD_W;

    logic [7:0]                         r_gain_p;
    logic [7:0]                         r_gain_d;
    logic [7:0]                         r_target;
    logic [7:0]                         r_base_speed;
    logic [7:0]                         r_turn_speed;
    logic [7:0]                         r_turn_thresh;
    logic [7:0]                         r_lost_error;
    logic [lfpd_pkg::CFG_W-1:0]         r_weights;

    lfpd_pkg::t_state                   r_state, n_state;
    logic [lfpd_pkg::NUM_LANES-1:0]     r_sens;
    logic signed [lfpd_pkg::POS_W-1:0]  r_pos;
    logic signed [lfpd_pkg::POS_W-1:0]  r_last_valid;
    logic                               r_lost;
    logic signed [W-1:0]                r_last_error;
    logic [W-1:0]                       r_up;
    logic [W-1:0]                       r_ud;
    logic [7:0]                         r_speed;
    logic                               r_out_valid;
    lfpd_pkg::t_drive                   r_left, r_right;
    logic signed [lfpd_pkg::POS_W-1:0]  r_out_pos;
    logic                               r_out_lost;

    lfpd_pkg::t_lane [lfpd_pkg::NUM_LANES-1:0] w_lanes;
    lfpd_pkg::t_merge                   w_merge;
    logic                               w_div_start;
    logic                               w_div_done;
    logic signed [lfpd_pkg::POS_W-1:0]  w_quot;
    logic                               w_load_out;
    logic signed [lfpd_pkg::POS_W-1:0]  w_lost_pos;
    logic signed [W-1:0]                w_err;
    logic [W-1:0]                       w_derr;
    logic [W+7:0]                       w_up_full;
    logic [W+7:0]                       w_ud_full;
    logic [lfpd_pkg::POS_W-1:0]         w_apos;
    logic [W-1:0]                       w_u;
    logic signed [W-1:0]                w_left, w_right;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p      <= '0;
            r_gain_d      <= '0;
            r_target      <= '0;
            r_base_speed  <= '0;
            r_turn_speed  <= '0;
            r_turn_thresh <= '0;
            r_lost_error  <= '0;
            r_weights     <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                lfpd_pkg::CFG_GAIN_P:      r_gain_p      <= i_cfg_data[7:0];
                lfpd_pkg::CFG_GAIN_D:      r_gain_d      <= i_cfg_data[7:0];
                lfpd_pkg::CFG_TARGET:      r_target      <= i_cfg_data[7:0];
                lfpd_pkg::CFG_BASE_SPEED:  r_base_speed  <= i_cfg_data[7:0];
                lfpd_pkg::CFG_TURN_SPEED:  r_turn_speed  <= i_cfg_data[7:0];
                lfpd_pkg::CFG_TURN_THRESH: r_turn_thresh <= i_cfg_data[7:0];
                lfpd_pkg::CFG_LOST_ERROR:  r_lost_error  <= i_cfg_data[7:0];
                lfpd_pkg::CFG_WEIGHTS:     r_weights     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // sensor lanes
    genvar g;
    generate
        for (g = 0; g < lfpd_pkg::NUM_LANES; g++) begin : g_lane
            lfpd_lane u_lane (
                .i_enable (g < lfpd_pkg::SENSOR_COUNT),
                .i_sensor (r_sens[g]),
                .i_weight (r_weights[g*lfpd_pkg::WEIGHT_W +: lfpd_pkg::WEIGHT_W]),
                .o_lane   (w_lanes[g])
            );
        end
    endgenerate

    lfpd_merge u_merge (
        .i_clk   (i_clk),
        .i_load  (r_state == lfpd_pkg::S_SUM),
        .i_lanes (w_lanes),
        .o_merge (w_merge)
    );

    assign w_div_start = (r_state == lfpd_pkg::S_CHK) && (w_merge.cnt != '0);

    lfpd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_merge.mag),
        .i_divisor  (w_merge.cnt),
        .i_neg      (w_merge.neg),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    // FSM
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lfpd_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_ready    = 1'b0;
        w_load_out = 1'b0;
        unique case (r_state)
            lfpd_pkg::S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_state = lfpd_pkg::S_SUM;
                end
            end
            lfpd_pkg::S_SUM: n_state = lfpd_pkg::S_CHK;
            lfpd_pkg::S_CHK: begin
                n_state = (w_merge.cnt == '0) ? lfpd_pkg::S_PD : lfpd_pkg::S_DIV;
            end
            lfpd_pkg::S_DIV: begin
                if (w_div_done) begin
                    n_state = lfpd_pkg::S_PD;
                end
            end
            lfpd_pkg::S_PD: n_state = lfpd_pkg::S_OUT;
            lfpd_pkg::S_OUT: begin
                if (!r_out_valid || i_ready) begin
                    w_load_out = 1'b1;
                    n_state    = lfpd_pkg::S_IDLE;
                end
            end
            default: n_state = lfpd_pkg::S_IDLE;
        endcase
    end

    // position
    assign w_lost_pos = (r_last_valid > 0) ? $signed({1'b0, r_lost_error})
                                           : -$signed({1'b0, r_lost_error});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_valid <= '0;
        end else if ((r_state == lfpd_pkg::S_DIV) && w_div_done) begin
            r_last_valid <= w_quot;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == lfpd_pkg::S_IDLE) && i_valid) begin
            r_sens <= {i_sensor_7, i_sensor_6, i_sensor_5, i_sensor_4,
                       i_sensor_3, i_sensor_2, i_sensor_1, i_sensor_0};
        end
        if ((r_state == lfpd_pkg::S_CHK) && (w_merge.cnt == '0)) begin
            r_pos  <= w_lost_pos;
            r_lost <= 1'b1;
        end else if ((r_state == lfpd_pkg::S_DIV) && w_div_done) begin
            r_pos  <= w_quot;
            r_lost <= 1'b0;
        end
    end

    // PD term
    assign w_err     = $signed({8'b0, r_target}) - $signed({{(W-lfpd_pkg::POS_W){r_pos[8]}}, r_pos});
    assign w_derr    = w_err - r_last_error;
    assign w_up_full = {{W{1'b0}}, r_gain_p} * {8'b0, w_err};
    assign w_ud_full = {{W{1'b0}}, r_gain_d} * {8'b0, w_derr};
    assign w_apos    = r_pos[lfpd_pkg::POS_W-1] ? -r_pos : r_pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_error <= '0;
        end else if (r_state == lfpd_pkg::S_PD) begin
            r_last_error <= w_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == lfpd_pkg::S_PD) begin
            r_up    <= w_up_full[W-1:0];
            r_ud    <= w_ud_full[W-1:0];
            r_speed <= (w_apos[7:0] >= r_turn_thresh) ? r_turn_speed : r_base_speed;
        end
    end

    // drive mix and output register
    assign w_u     = r_up + r_ud;
    assign w_left  = $signed({8'b0, r_speed} + w_u);
    assign w_right = $signed({8'b0, r_speed} - w_u);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_left     <= lfpd_pkg::clamp_drive(w_left);
            r_right    <= lfpd_pkg::clamp_drive(w_right);
            r_out_pos  <= r_pos;
            r_out_lost <= r_lost;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_left_drive    = r_left.mag;
    assign o_left_reverse  = r_left.rev;
    assign o_right_drive   = r_right.mag;
    assign o_right_reverse = r_right.rev;
    assign o_line_position = r_out_pos;
    assign o_line_lost     = r_out_lost;

    a_drive_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_left_drive <= 8'(lfpd_pkg::MAX_DRIVE))
                 && (o_right_drive <= 8'(lfpd_pkg::MAX_DRIVE)))
        else $error("drive magnitude above limit");

    a_reverse_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_left_reverse || o_right_reverse) |->
            (!o_left_reverse || o_left_drive != '0)
         && (!o_right_reverse || o_right_drive != '0))
        else $error("reverse flag with zero magnitude");

    a_div_in_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> r_state == lfpd_pkg::S_DIV)
        else $error("divider finished outside the divide step");

    a_out_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load_out |=> o_valid && r_state == lfpd_pkg::S_IDLE)
        else $error("result load did not present a beat");

endmodule
